>>> hw/rtl/xtea_ctr_stream_cipher_assert.svh
// assertion macros shared by the xtea counter-mode cipher rtl
`ifndef XTEA_CTR_STREAM_CIPHER_ASSERT_SVH
`define XTEA_CTR_STREAM_CIPHER_ASSERT_SVH

`ifndef ASSERT_OFF

// plain property check, disabled during reset
`define XCS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// same-cycle implication
`define XCS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication failed");

// next-cycle implication
`define XCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`else

`define XCS_ASSERT(lbl, clk, rst_n, prop)
`define XCS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define XCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/xtea_pkg.sv
// shared types, constants and helper functions of the xtea counter-mode cipher
`timescale 1ns / 1ps
`default_nettype none

package xtea_pkg;

	localparam int ROUNDS = 32;
	localparam int CELLS = 2 * ROUNDS;
	localparam logic [31:0] XTEA_DELTA = 32'h9E37_79B9;
	localparam logic [3:0] MAX_BYTES = 4'd8;

	// one item as it moves down the row of half-round cells
	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [63:0] data;
		logic [3:0] count;
	} lane_t;

	// round sum seen by a given half-round cell
	function automatic logic [31:0] cell_acc(input int idx);
		logic [31:0] n;
		n = 32'((idx >> 1) + (idx & 1));
		return n * XTEA_DELTA;
	endfunction

	// key word select for a given half-round cell
	function automatic logic [1:0] cell_sel(input int idx);
		logic [31:0] acc;
		acc = cell_acc(idx);
		return ((idx & 1) != 0) ? acc[12:11] : acc[1:0];
	endfunction

	// byte mask for a saturated count of 0..8
	function automatic logic [63:0] byte_mask(input logic [3:0] count);
		logic [63:0] m;
		for (int i = 0; i < 8; i++) begin
			m[8*i +: 8] = (4'(i) < count) ? 8'hFF : 8'h00;
		end
		return m;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/xtea_cell.sv
// one xtea half-round cell with its own pipeline register and handshake
`timescale 1ns / 1ps
`default_nettype none

module xtea_cell import xtea_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [31:0] subkey,
	input  wire logic        up_valid,
	output logic             up_ready,
	input  wire lane_t       up_lane,
	output logic             dn_valid,
	input  wire logic        dn_ready,
	output lane_t            dn_lane
);

	logic        vld_s1;
	lane_t       lane_s1;
	logic [31:0] mix;
	logic [31:0] x_new;

	// x += (((y << 4) ^ (y >> 5)) + y) ^ subkey, then swap halves
	always_comb begin
		mix = ((up_lane.y << 4) ^ (up_lane.y >> 5)) + up_lane.y;
		x_new = up_lane.x + (mix ^ subkey);
	end

	assign up_ready = !vld_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (up_ready) begin
			vld_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			lane_s1.x <= up_lane.y;
			lane_s1.y <= x_new;
			lane_s1.data <= up_lane.data;
			lane_s1.count <= up_lane.count;
		end
	end

	assign dn_valid = vld_s1;
	assign dn_lane = lane_s1;

endmodule

`default_nettype wire

>>> hw/rtl/xtea_ctr_stream_cipher.sv
// top level: xtea counter-mode stream cipher with an apb key port
//
// channel   dir   handshake                 contents
// s_*       in    s_tvalid / s_tready       data bytes, byte count, block id, start flag
// m_*       out   m_tvalid / m_tready       xored bytes, byte count
// apb       in    psel, penable, pready     key words 0..3 at byte addresses 0, 4, 8, 12
//
// one item per cycle when the output side takes every item
// the path holds an entry register, one register per half-round cell and an output register
// each cell stalls only when its neighbor downstream is full and stalled, so bubbles close up
// reset clears the valid bits, block counter and block id; keys reset to zero
`timescale 1ns / 1ps
`default_nettype none

`include "xtea_ctr_stream_cipher_assert.svh"

module xtea_ctr_stream_cipher import xtea_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// [63:0] in_data, [67:64] byte_count, [99:68] block_id, [103:100] zero
	input  wire logic [103:0] s_tdata,
	// [0] start_req
	input  wire logic [0:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// [63:0] out_data, [67:64] out_count, [71:68] zero
	output logic [71:0]       m_tdata,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [3:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [31:0] key_q [4];
	logic [31:0] subkey_q [CELLS];
	logic [31:0] nonce_q;
	logic [31:0] ctr_q;

	logic        s_accept;
	logic [63:0] in_data;
	logic [3:0]  byte_count;
	logic [31:0] block_id;
	logic        start_req;
	logic [3:0]  count_sat;

	logic        vld_s0;
	lane_t       lane_s0;
	logic        vld_s2;
	logic [63:0] data_s2;
	logic [3:0]  count_s2;
	logic        out_ready;

	logic        vld_c [CELLS+1];
	logic        rdy_c [CELLS+1];
	lane_t       lane_c [CELLS+1];

	// apb key registers
	assign pready = 1'b1;
	assign prdata = key_q[paddr[3:2]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				key_q[i] <= '0;
			end
		end else if (psel && penable && pwrite && pready) begin
			key_q[paddr[3:2]] <= pwdata;
		end
	end

	// input unpack
	assign in_data = s_tdata[63:0];
	assign byte_count = s_tdata[67:64];
	assign block_id = s_tdata[99:68];
	assign start_req = s_tuser[0];
	assign count_sat = (byte_count inside {[4'd9:4'd15]}) ? MAX_BYTES : byte_count;

	assign s_tready = !vld_s0 || rdy_c[0];
	assign s_accept = s_tvalid && s_tready;

	// counter block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nonce_q <= '0;
			ctr_q <= '0;
		end else if (s_accept) begin
			if (start_req) begin
				nonce_q <= block_id;
				ctr_q <= 32'd1;
			end else begin
				ctr_q <= ctr_q + 32'd1;
			end
		end
	end

	// entry stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (s_tready) begin
			vld_s0 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			lane_s0.x <= start_req ? block_id : nonce_q;
			lane_s0.y <= start_req ? 32'd0 : ctr_q;
			lane_s0.data <= in_data;
			lane_s0.count <= count_sat;
		end
	end

	assign vld_c[0] = vld_s0;
	assign lane_c[0] = lane_s0;

	// row of half-round cells, each with its round sum folded into the key word
	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		localparam logic [31:0] ACC = cell_acc(i);
		localparam logic [1:0] SEL = cell_sel(i);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				subkey_q[i] <= ACC;
			end else begin
				subkey_q[i] <= ACC + key_q[SEL];
			end
		end

		xtea_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.subkey   (subkey_q[i]),
			.up_valid (vld_c[i]),
			.up_ready (rdy_c[i]),
			.up_lane  (lane_c[i]),
			.dn_valid (vld_c[i+1]),
			.dn_ready (rdy_c[i+1]),
			.dn_lane  (lane_c[i+1])
		);
	end

	// output stage: xor with keystream and clear unused bytes
	assign out_ready = !vld_s2 || m_tready;
	assign rdy_c[CELLS] = out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (out_ready) begin
			vld_s2 <= vld_c[CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && vld_c[CELLS]) begin
			data_s2 <= (lane_c[CELLS].data ^ {lane_c[CELLS].y, lane_c[CELLS].x})
				& byte_mask(lane_c[CELLS].count);
			count_s2 <= lane_c[CELLS].count;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata = {4'd0, count_s2, data_s2};

	`XCS_ASSERT_IMPL(a_count_range, clk, arst_n, vld_s2, count_s2 <= MAX_BYTES)
	`XCS_ASSERT_IMPL(a_zero_count_clear, clk, arst_n, vld_s2 && count_s2 == 4'd0, data_s2 == 64'd0)
	`XCS_ASSERT_NEXT(a_ctr_step, clk, arst_n, s_accept && !start_req, ctr_q == $past(ctr_q) + 32'd1)
	`XCS_ASSERT_NEXT(a_start_load, clk, arst_n, s_accept && start_req, ctr_q == 32'd1 && nonce_q == $past(block_id))
	`XCS_ASSERT_NEXT(a_idle_hold, clk, arst_n, !s_accept, ctr_q == $past(ctr_q))

endmodule

`default_nettype wire
